>>> rtl/mp3ar_pkg.sv
// ----------------------------------------------------------------------------
// mp3ar_pkg
// Shared constants, types and coefficient tables for the alias-reduction block
// ----------------------------------------------------------------------------
package mp3ar_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int POS_W         = 10;
  localparam int SUB_W         = 5;
  localparam int SEL_W         = 3;
  localparam int WIN_DEPTH     = 16;
  localparam int WIN_IDX_W     = 4;
  localparam int DELAY         = 15;
  localparam int BFLY_N        = 8;
  localparam int SUBBAND_LINES = 18;
  localparam int GRANULE_LINES = 576;
  localparam int COEF_W        = 29;
  localparam int PROD_W        = SAMPLE_W + COEF_W;
  localparam int SUM_W         = PROD_W + 1;
  localparam int Q_SHIFT       = 28;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } win_state_t;

  // per-line control carried down the pipeline
  typedef struct packed {
    logic                 bf;
    logic [SEL_W-1:0]     sel;
    logic                 last;
    logic                 full;
    logic [WIN_IDX_W-1:0] pos_lo;
  } ctl_t;

  // status of the window stage
  typedef struct packed {
    logic commit;
    logic flushing;
  } win_st_t;

  function automatic logic signed [COEF_W-1:0] coef_cs(input logic [SEL_W-1:0] i);
    logic signed [COEF_W-1:0] c;
    unique case (i)
      3'd0: c = 29'h0db84a81;
      3'd1: c = 29'h0e1b9d7f;
      3'd2: c = 29'h0f31adcf;
      3'd3: c = 29'h0fbba815;
      3'd4: c = 29'h0feda417;
      3'd5: c = 29'h0ffc8fc8;
      3'd6: c = 29'h0fff964c;
      default: c = 29'h0ffff8d3;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_ca(input logic [SEL_W-1:0] i);
    logic signed [COEF_W-1:0] c;
    unique case (i)
      3'd0: c = 29'h083b5fe7;
      3'd1: c = 29'h078c36d2;
      3'd2: c = 29'h05039814;
      3'd3: c = 29'h02e91dd1;
      3'd4: c = 29'h0183603a;
      3'd5: c = 29'h00a7cb87;
      3'd6: c = 29'h003a2847;
      default: c = 29'h000f27b4;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/mp3ar_front.sv
// ----------------------------------------------------------------------------
// mp3ar_front
// Input register, line/subband tracking, raw history and upper-line select
// ----------------------------------------------------------------------------
module mp3ar_front import mp3ar_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // [31:0] sample
  input  logic                in_tuser,   // [0] short_block
  input  logic                in_tlast,
  input  logic                cfg_we,
  input  logic [POS_W-1:0]    cfg_wdata,
  input  logic                dn_ready,
  output logic                s1_v,
  output logic [SAMPLE_W-1:0] s1_a,
  output logic [SAMPLE_W-1:0] s1_b,
  output ctl_t                s1_ctl
);

  logic [POS_W-1:0]    pos_r, base_r, active_r;
  logic [SUB_W-1:0]    sub_r;
  logic [SAMPLE_W-1:0] raw_r [WIN_DEPTH-1];
  logic                s1_v_r;
  logic [SAMPLE_W-1:0] s1_a_r, s1_b_r;
  ctl_t                s1_ctl_r, ctl_nxt;
  logic                acc, last_eff;

  assign in_tready = !s1_v_r || dn_ready;
  assign acc       = in_tvalid && in_tready;
  assign last_eff  = in_tlast || (pos_r == POS_W'(GRANULE_LINES - 1));

  always_comb begin
    ctl_nxt.bf     = !in_tuser && (sub_r < SUB_W'(BFLY_N)) && (base_r != '0) &&
                     (base_r < active_r);
    ctl_nxt.sel    = sub_r[SEL_W-1:0];
    ctl_nxt.last   = last_eff;
    ctl_nxt.full   = (pos_r >= POS_W'(DELAY));
    ctl_nxt.pos_lo = pos_r[WIN_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      base_r   <= '0;
      sub_r    <= '0;
      active_r <= POS_W'(GRANULE_LINES);
      s1_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
      if (acc) begin
        s1_v_r <= 1'b1;
        if (last_eff) begin
          pos_r  <= '0;
          base_r <= '0;
          sub_r  <= '0;
        end else begin
          pos_r <= pos_r + POS_W'(1);
          if (sub_r == SUB_W'(SUBBAND_LINES - 1)) begin
            sub_r  <= '0;
            base_r <= base_r + POS_W'(SUBBAND_LINES);
          end else begin
            sub_r <= sub_r + SUB_W'(1);
          end
        end
      end else if (dn_ready) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  // raw history: entry k holds the line accepted k+1 beats ago
  always_ff @(posedge clk) begin
    if (acc) begin
      raw_r[0] <= in_tdata;
      for (int k = 1; k < WIN_DEPTH - 1; k++) begin
        raw_r[k] <= raw_r[k-1];
      end
      // upper partner sits 2*sel+1 lines back
      s1_a_r   <= raw_r[{sub_r[SEL_W-1:0], 1'b0}];
      s1_b_r   <= in_tdata;
      s1_ctl_r <= ctl_nxt;
    end
  end

  assign s1_v   = s1_v_r;
  assign s1_a   = s1_a_r;
  assign s1_b   = s1_b_r;
  assign s1_ctl = s1_ctl_r;

endmodule

>>> rtl/mp3ar_mult.sv
// ----------------------------------------------------------------------------
// mp3ar_mult
// Product stage: the four butterfly products of one line pair
// ----------------------------------------------------------------------------
module mp3ar_mult import mp3ar_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_v,
  output logic                       up_ready,
  input  logic [SAMPLE_W-1:0]        up_a,
  input  logic [SAMPLE_W-1:0]        up_b,
  input  ctl_t                       up_ctl,
  input  logic                       dn_ready,
  output logic                       s2_v,
  output logic signed [PROD_W-1:0]   p_acs,
  output logic signed [PROD_W-1:0]   p_aca,
  output logic signed [PROD_W-1:0]   p_bcs,
  output logic signed [PROD_W-1:0]   p_bca,
  output logic [SAMPLE_W-1:0]        s2_b,
  output ctl_t                       s2_ctl
);

  logic                     s2_v_r;
  logic signed [PROD_W-1:0] acs_r, aca_r, bcs_r, bca_r;
  logic signed [PROD_W-1:0] acs_nxt, aca_nxt, bcs_nxt, bca_nxt;
  logic [SAMPLE_W-1:0]      b_r;
  ctl_t                     ctl_r;
  logic signed [SAMPLE_W-1:0] a_s, b_s;
  logic signed [COEF_W-1:0]   cs, ca;
  logic                       load;

  assign up_ready = !s2_v_r || dn_ready;
  assign load     = up_v && up_ready;

  always_comb begin
    a_s     = signed'(up_a);
    b_s     = signed'(up_b);
    cs      = coef_cs(up_ctl.sel);
    ca      = coef_ca(up_ctl.sel);
    acs_nxt = PROD_W'(a_s) * PROD_W'(cs);
    aca_nxt = PROD_W'(a_s) * PROD_W'(ca);
    bcs_nxt = PROD_W'(b_s) * PROD_W'(cs);
    bca_nxt = PROD_W'(b_s) * PROD_W'(ca);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (load) begin
      s2_v_r <= 1'b1;
    end else if (dn_ready) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acs_r <= acs_nxt;
      aca_r <= aca_nxt;
      bcs_r <= bcs_nxt;
      bca_r <= bca_nxt;
      b_r   <= up_b;
      ctl_r <= up_ctl;
    end
  end

  assign s2_v   = s2_v_r;
  assign p_acs  = acs_r;
  assign p_aca  = aca_r;
  assign p_bcs  = bcs_r;
  assign p_bca  = bca_r;
  assign s2_b   = b_r;
  assign s2_ctl = ctl_r;

endmodule

>>> rtl/mp3ar_window.sv
// ----------------------------------------------------------------------------
// mp3ar_window
// Butterfly sums, saturation, 16-line window, end-of-granule flush and output
// ----------------------------------------------------------------------------
module mp3ar_window import mp3ar_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     s2_v,
  input  logic signed [PROD_W-1:0] p_acs,
  input  logic signed [PROD_W-1:0] p_aca,
  input  logic signed [PROD_W-1:0] p_bcs,
  input  logic signed [PROD_W-1:0] p_bca,
  input  logic [SAMPLE_W-1:0]      s2_b,
  input  ctl_t                     s2_ctl,
  output win_st_t                  st,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [SAMPLE_W-1:0]      out_tdata,   // [31:0] sample_out
  output logic                     out_tlast
);

  localparam int SH_W = SUM_W - Q_SHIFT;

  function automatic logic [SAMPLE_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
    logic signed [SH_W-1:0] s;
    logic [SAMPLE_W-1:0]    r;
    s = v[SUM_W-1:Q_SHIFT];
    if (s[SH_W-1:SAMPLE_W-1] == '0 || s[SH_W-1:SAMPLE_W-1] == '1) begin
      r = s[SAMPLE_W-1:0];
    end else if (s[SH_W-1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

  win_state_t           state_r, state_nxt;
  logic [SAMPLE_W-1:0]  w_r [WIN_DEPTH];
  logic [SAMPLE_W-1:0]  w_nxt [WIN_DEPTH];
  logic [WIN_IDX_W-1:0] skip_r, skip_nxt, cnt_r, cnt_nxt;
  logic                 out_v_r, out_v_nxt, out_l_r, out_l_nxt;
  logic [SAMPLE_W-1:0]  out_d_r, out_d_nxt;
  logic signed [SUM_W-1:0] up_sum, lo_sum;
  logic [SAMPLE_W-1:0]  up_val, lo_val;
  logic                 out_free, emits, commit;

  assign out_free = !out_v_r || out_tready;
  assign emits    = s2_ctl.full && !s2_ctl.last;
  assign commit   = (state_r == ST_RUN) && s2_v && (out_free || !emits);

  always_comb begin
    up_sum = SUM_W'(p_acs) + SUM_W'(p_bca);
    lo_sum = SUM_W'(p_bcs) - SUM_W'(p_aca);
    up_val = sat_q(up_sum);
    lo_val = s2_ctl.bf ? sat_q(lo_sum) : s2_b;
  end

  always_comb begin
    w_nxt     = w_r;
    state_nxt = state_r;
    skip_nxt  = skip_r;
    cnt_nxt   = cnt_r;
    out_v_nxt = out_v_r && !out_tready;
    out_d_nxt = out_d_r;
    out_l_nxt = out_l_r;
    unique case (state_r)
      ST_RUN: begin
        if (commit) begin
          w_nxt[0] = lo_val;
          for (int k = 1; k < WIN_DEPTH; k++) begin
            w_nxt[k] = w_r[k-1];
          end
          if (s2_ctl.bf) begin
            w_nxt[{s2_ctl.sel, 1'b1}] = up_val;
          end
          if (emits) begin
            out_v_nxt = 1'b1;
            out_d_nxt = w_nxt[WIN_DEPTH-1];
            out_l_nxt = 1'b0;
          end
          if (s2_ctl.last) begin
            state_nxt = ST_FLUSH;
            // short granule: shift the unused older slots out silently first
            skip_nxt  = s2_ctl.full ? '0 : WIN_IDX_W'(DELAY) - s2_ctl.pos_lo;
            cnt_nxt   = s2_ctl.full ? WIN_IDX_W'(WIN_DEPTH - 1) : s2_ctl.pos_lo;
          end
        end
      end
      ST_FLUSH: begin
        if (skip_r != '0) begin
          for (int k = 1; k < WIN_DEPTH; k++) begin
            w_nxt[k] = w_r[k-1];
          end
          skip_nxt = skip_r - WIN_IDX_W'(1);
        end else if (out_free) begin
          out_v_nxt = 1'b1;
          out_d_nxt = w_r[WIN_DEPTH-1];
          out_l_nxt = (cnt_r == '0);
          for (int k = 1; k < WIN_DEPTH; k++) begin
            w_nxt[k] = w_r[k-1];
          end
          if (cnt_r == '0) begin
            state_nxt = ST_RUN;
          end else begin
            cnt_nxt = cnt_r - WIN_IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      skip_r  <= '0;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      skip_r  <= skip_nxt;
      cnt_r   <= cnt_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    out_d_r <= out_d_nxt;
    out_l_r <= out_l_nxt;
  end

  assign st.commit   = commit;
  assign st.flushing = (state_r == ST_FLUSH);
  assign out_tvalid  = out_v_r;
  assign out_tdata   = out_d_r;
  assign out_tlast   = out_l_r;

endmodule

>>> rtl/mp3_alias_reduction.sv
// ----------------------------------------------------------------------------
// mp3_alias_reduction
// Layer III alias-reduction butterflies on a stream of frequency lines
// ----------------------------------------------------------------------------
// Takes one line per beat and returns the lines in their original order 15
// lines behind the input, so one result beat per input beat in steady state.
// A line travels through an input register, a product register (four 32x29
// multiplies) and the window stage where sums are shifted, saturated and
// written into a 16-line shift window; a result leaves through an output
// register, so the first result of a granule follows its sixteenth line through
// the input, product and output registers. The final line of a granule (tlast,
// or line 576) starts a flush, which sink stalls lengthen, while the window
// shifts out the lines it still holds, one per cycle when the sink is ready; in
// that time the two front registers may still take up to two lines of the next
// granule. The window has no reset and needs no clearing pass. active_lines
// may be written only while the block is idle.
module mp3_alias_reduction import mp3ar_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // [31:0] sample
  input  logic                in_tuser,   // [0] short_block
  input  logic                in_tlast,   // last_line
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_tdata,  // [31:0] sample_out
  output logic                out_tlast,  // last_out
  input  logic                cfg_we,
  input  logic [POS_W-1:0]    cfg_wdata   // active_lines
);

  logic                     s1_v, s2_v, s2_ready;
  logic [SAMPLE_W-1:0]      s1_a, s1_b, s2_b;
  ctl_t                     s1_ctl, s2_ctl;
  logic signed [PROD_W-1:0] p_acs, p_aca, p_bcs, p_bca;
  win_st_t                  st;

  mp3ar_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .dn_ready  (s2_ready),
    .s1_v      (s1_v),
    .s1_a      (s1_a),
    .s1_b      (s1_b),
    .s1_ctl    (s1_ctl)
  );

  mp3ar_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_v     (s1_v),
    .up_ready (s2_ready),
    .up_a     (s1_a),
    .up_b     (s1_b),
    .up_ctl   (s1_ctl),
    .dn_ready (st.commit),
    .s2_v     (s2_v),
    .p_acs    (p_acs),
    .p_aca    (p_aca),
    .p_bcs    (p_bcs),
    .p_bca    (p_bca),
    .s2_b     (s2_b),
    .s2_ctl   (s2_ctl)
  );

  mp3ar_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_v       (s2_v),
    .p_acs      (p_acs),
    .p_aca      (p_aca),
    .p_bcs      (p_bcs),
    .p_bca      (p_bca),
    .s2_b       (s2_b),
    .s2_ctl     (s2_ctl),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // nothing enters the window while it is being flushed
  a_no_commit_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    st.flushing |-> !st.commit)
    else $error("line committed during flush");

  // a line waiting in the product stage is not dropped
  a_s2_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v && !st.commit) |=> s2_v)
    else $error("product stage lost a line");

  // a flush ends with the final line of the granule in the output register
  a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(st.flushing) |-> (out_tvalid && out_tlast))
    else $error("flush ended without final beat");

  // a last beat is only loaded by the flush
  a_last_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast && !$past(out_tvalid && out_tlast)) |-> $past(st.flushing))
    else $error("last beat outside flush");

endmodule
